// ===== sv/id_tracking_table_top_assert.svh =====
// assertion macros for the id tracking table
`ifndef ID_TRACKING_TABLE_TOP_ASSERT_SVH
`define ID_TRACKING_TABLE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ITT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("itt assertion failed");
`define ITT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("itt assertion failed");
`else
`define ITT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ITT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/itt_pkg.sv =====
// types and constants shared by the id tracking table modules
package itt_pkg;

    localparam int ID_W = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_POP    = 2'd3
    } cmd_t;

    // request travelling down the row of cells
    typedef struct packed {
        logic              valid;
        cmd_t              cmd;
        logic [ID_W-1:0]   id;
        logic              started;
        logic              done;
        logic              ok;
        logic [ID_W-1:0]   popped;
        logic [ID_W-1:0]   prev;
    } wave_t;

endpackage

// ===== sv/id_tracking_table_top.sv =====
// id tracking table: a row of slot cells that each request walks through
//
//  channel  | direction | tdata (lsb up)            | tuser
//  s_       | in        | id[31:0]                  | command[1:0]
//  m_       | out       | ok[0], popped_id[32:1]    | -
//
// a request walks the row one cell per cycle while the output is not stalled;
// it passes each cell's request register in turn and then the output register,
// and no new request is taken until it has left the last cell.
// the row holds one request at a time; a waiting result freezes the row.
// reset clears every slot and the started flag.
`include "id_tracking_table_top_assert.svh"

module id_tracking_table_top
    import itt_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // id[31:0]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // ok[0], popped_id[32:1], zero fill
);

    logic        busy_reg;
    logic        started_reg;
    logic        m_tvalid_reg;
    logic        ok_reg;
    logic [ID_W-1:0] popped_reg;

    logic        accept;
    logic        adv;
    wave_t       entry;
    wave_t       wave_out [ENTRIES];
    logic        clr_up   [ENTRIES];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    assign adv      = !m_tvalid_reg || m_tready;

    always_comb begin
        entry         = '0;
        entry.valid   = 1'b1;
        entry.cmd     = cmd_t'(s_tuser);
        entry.id      = s_tdata;
        entry.started = started_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            logic  load_c;
            wave_t win_c;
            logic  clr_c;
            if (gi == 0) begin : g_head
                assign load_c = accept || adv;
                assign win_c  = accept ? entry : '0;
            end else begin : g_body
                assign load_c = adv;
                assign win_c  = wave_out[gi-1];
            end
            if (gi == ENTRIES - 1) begin : g_tail
                assign clr_c = 1'b0;
            end else begin : g_mid
                assign clr_c = clr_up[gi+1];
            end
            itt_cell #(
                .IS_FIRST (gi == 0)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .load     (load_c),
                .adv      (adv),
                .wave_in  (win_c),
                .clr_in   (clr_c),
                .wave_out (wave_out[gi]),
                .clr_prev (clr_up[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            started_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept && (cmd_t'(s_tuser) == CMD_INSERT)) begin
                started_reg <= 1'b1;
            end
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (adv && wave_out[ENTRIES-1].valid) begin
                busy_reg <= 1'b0;
            end
            if (adv) begin
                m_tvalid_reg <= wave_out[ENTRIES-1].valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && wave_out[ENTRIES-1].valid) begin
            ok_reg     <= wave_out[ENTRIES-1].ok;
            popped_reg <= wave_out[ENTRIES-1].popped;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, popped_reg, ok_reg};

    `ITT_ASSERT_IMPL(a_ok_excl_pop, aclk, aresetn, m_tvalid_reg, !(ok_reg && (popped_reg != '0)))
    `ITT_ASSERT_IMPL(a_idle_row_empty, aclk, aresetn, !busy_reg, !wave_out[ENTRIES-1].valid)
    `ITT_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, busy_reg)
    `ITT_ASSERT_IMPL(a_done_result, aclk, aresetn, $fell(busy_reg), m_tvalid_reg)

endmodule

// ===== sv/itt_cell.sv =====
// one table slot with the request register in front of it
module itt_cell
    import itt_pkg::*;
#(
    parameter bit IS_FIRST = 1'b0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  load,
    input  logic  adv,
    input  wave_t wave_in,
    input  logic  clr_in,
    output wave_t wave_out,
    output logic  clr_prev
);

    wave_t           wave_reg;
    logic [ID_W-1:0] slot_reg;
    logic [ID_W-1:0] slot_next;
    logic            is_zero;
    logic            hit;

    assign is_zero = (slot_reg == '0);
    assign hit     = (slot_reg == wave_reg.id);

    always_comb begin
        wave_out  = wave_reg;
        slot_next = slot_reg;
        clr_prev  = 1'b0;
        if (wave_reg.valid && !wave_reg.done) begin
            case (wave_reg.cmd)
                CMD_INSERT: begin
                    if (is_zero) begin
                        slot_next     = wave_reg.id;
                        wave_out.ok   = 1'b1;
                        wave_out.done = 1'b1;
                    end
                end
                CMD_QUERY: begin
                    if (hit) begin
                        wave_out.ok   = wave_reg.started;
                        wave_out.done = 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (hit) begin
                        slot_next     = '0;
                        wave_out.done = 1'b1;
                    end
                end
                CMD_POP: begin
                    // lowest empty slot: hand back and clear the one below
                    if (is_zero) begin
                        wave_out.done = 1'b1;
                        if (!IS_FIRST) begin
                            wave_out.popped = wave_reg.prev;
                            clr_prev        = 1'b1;
                        end
                    end
                end
                default: begin
                    wave_out.done = 1'b1;
                end
            endcase
        end
        wave_out.prev = slot_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg <= '0;
            slot_reg <= '0;
        end else begin
            if (load) begin
                wave_reg <= wave_in;
            end
            if (adv) begin
                if (clr_in) begin
                    slot_reg <= '0;
                end else begin
                    slot_reg <= slot_next;
                end
            end
        end
    end

endmodule
